// ===== hw/rtl/fscp_pkg.sv =====
// Shared types and constants for the framed servo command parser.
// Character codes, action codes, number field phases and byte class helpers.
// No dependencies.
package fscp_pkg;

   localparam logic [7:0] CHAR_START = 8'h3C;  // '<'
   localparam logic [7:0] CHAR_END   = 8'h3E;  // '>'
   localparam logic [7:0] CHAR_S     = 8'h53;
   localparam logic [7:0] CHAR_P     = 8'h50;
   localparam logic [7:0] CHAR_A     = 8'h41;
   localparam logic [7:0] CHAR_D     = 8'h44;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   localparam logic [1:0] ACT_SET    = 2'd0;
   localparam logic [1:0] ACT_ATTACH = 2'd1;
   localparam logic [1:0] ACT_DETACH = 2'd2;

   localparam logic [15:0] MAG_CAP   = 16'h8000;
   localparam logic [15:0] POS_MAX   = 16'h7FFF;

   typedef enum logic [1:0] {
      PH_SKIP,
      PH_SIGN,
      PH_DIGITS,
      PH_DONE
   } num_phase_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
   endfunction

endpackage

// ===== hw/rtl/framed_servo_command_parser.sv =====
// Framed servo command parser: top level, one byte per cycle unless stalled.
// Depends on fscp_pkg for character codes, action codes and helpers.
//
// Takes one received byte per request and emits a command at most once per
// frame, at the closing '>'. A frame opens with '<'; up to MAX_FRAME_CHARS
// bytes are kept and the rest ignored until '>'. The frame yields a command
// when char 0 is the digit equal to the board address, char 1 is 'S', char 2
// is 'P' (set position), 'A' (attach) or 'D' (detach) and char 3 is the servo
// digit. For set position the signed decimal value after char 3 is read with
// leading whitespace skipped, an optional sign, and saturation to 16 bits;
// attach and detach report position 0. Every byte is handled on acceptance:
// the frame state updates as the request is accepted and a finished command
// goes to an output register, so a request is accepted in every cycle in
// which the output register is empty or being emptied. The first command
// appears on the result channel in the cycle after its '>' is accepted. The
// board address may be changed only while no command is pending.
module framed_servo_command_parser
   import fscp_pkg::*;
#(
   parameter int MAX_FRAME_CHARS = 30
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [3:0]         csr_wr_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_action,
   output logic [3:0]         rsp_servo_number,
   output logic signed [15:0] rsp_position
);

   localparam int CW = $clog2(MAX_FRAME_CHARS + 1);
   localparam logic [CW-1:0] CNT_MAX = CW'(MAX_FRAME_CHARS);
   localparam logic [CW-1:0] CNT_ADDR = CW'(0);
   localparam logic [CW-1:0] CNT_CMD = CW'(1);
   localparam logic [CW-1:0] CNT_SUB = CW'(2);
   localparam logic [CW-1:0] CNT_SERVO = CW'(3);
   localparam logic [CW-1:0] CNT_MIN = CW'(4);

   logic [3:0]    board_address_ff;
   logic          in_frame_ff, in_frame_in;
   logic [CW-1:0] char_count_ff, char_count_in;
   logic [7:0]    address_char_ff, address_char_in;
   logic [7:0]    command_char_ff, command_char_in;
   logic [7:0]    sub_char_ff, sub_char_in;
   logic [7:0]    servo_char_ff, servo_char_in;
   num_phase_type phase_ff, phase_in;
   logic          negative_ff, negative_in;
   logic [15:0]   magnitude_ff, magnitude_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_action_ff, rsp_action_in;
   logic [3:0]    rsp_servo_ff, rsp_servo_in;
   logic [15:0]   rsp_position_ff, rsp_position_in;

   logic          req_fire;
   logic          hit;
   logic [7:0]    c;
   logic [19:0]   mag_wide;
   logic [19:0]   digit_sum;
   logic [15:0]   digit_mag;
   logic          frame_ok;
   logic [15:0]   set_position;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign c         = req_rx_byte;

   // Decimal accumulate: magnitude * 10 + digit, capped at 32768.
   assign mag_wide  = 20'(magnitude_ff);
   assign digit_sum = (mag_wide << 3) + (mag_wide << 1) + 20'(c[3:0]);
   assign digit_mag = (digit_sum > 20'(MAG_CAP)) ? MAG_CAP : digit_sum[15:0];

   // Char 0 low nibble equals the address only for digits 0..9, so an address
   // above 9 never matches.
   assign frame_ok = (char_count_ff >= CNT_MIN)
                     && is_digit(address_char_ff)
                     && (address_char_ff[3:0] == board_address_ff)
                     && (command_char_ff == CHAR_S)
                     && is_digit(servo_char_ff);

   assign set_position = negative_ff ? (~magnitude_ff + 16'd1)
                       : (magnitude_ff[15] ? POS_MAX : magnitude_ff);

   always_comb begin
      in_frame_in     = in_frame_ff;
      char_count_in   = char_count_ff;
      address_char_in = address_char_ff;
      command_char_in = command_char_ff;
      sub_char_in     = sub_char_ff;
      servo_char_in   = servo_char_ff;
      phase_in        = phase_ff;
      negative_in     = negative_ff;
      magnitude_in    = magnitude_ff;
      hit             = 1'b0;
      rsp_action_in   = rsp_action_ff;
      rsp_servo_in    = rsp_servo_ff;
      rsp_position_in = rsp_position_ff;

      if (req_fire) begin
         if (!in_frame_ff) begin
            if (c == CHAR_START) begin
               in_frame_in     = 1'b1;
               char_count_in   = '0;
               address_char_in = '0;
               command_char_in = '0;
               sub_char_in     = '0;
               servo_char_in   = '0;
               phase_in        = PH_SKIP;
               negative_in     = 1'b0;
               magnitude_in    = '0;
            end
         end else if (c != CHAR_END) begin
            if (char_count_ff < CNT_MAX) begin
               char_count_in = char_count_ff + CW'(1);
               if (char_count_ff == CNT_ADDR) begin
                  address_char_in = c;
               end else if (char_count_ff == CNT_CMD) begin
                  command_char_in = c;
               end else if (char_count_ff == CNT_SUB) begin
                  sub_char_in = c;
               end else if (char_count_ff == CNT_SERVO) begin
                  servo_char_in = c;
               end else begin
                  case (phase_ff)
                     PH_SKIP: begin
                        if (is_space(c)) begin
                           phase_in = PH_SKIP;
                        end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
                           negative_in = (c == CHAR_MINUS);
                           phase_in    = PH_SIGN;
                        end else if (is_digit(c)) begin
                           magnitude_in = digit_mag;
                           phase_in     = PH_DIGITS;
                        end else begin
                           phase_in = PH_DONE;
                        end
                     end
                     PH_SIGN, PH_DIGITS: begin
                        if (is_digit(c)) begin
                           magnitude_in = digit_mag;
                           phase_in     = PH_DIGITS;
                        end else begin
                           phase_in = PH_DONE;
                        end
                     end
                     default: begin
                        phase_in = PH_DONE;
                     end
                  endcase
               end
            end
         end else begin
            in_frame_in = 1'b0;
            if (frame_ok) begin
               rsp_servo_in = servo_char_ff[3:0];
               case (sub_char_ff)
                  CHAR_P: begin
                     hit             = 1'b1;
                     rsp_action_in   = ACT_SET;
                     rsp_position_in = set_position;
                  end
                  CHAR_A: begin
                     hit             = 1'b1;
                     rsp_action_in   = ACT_ATTACH;
                     rsp_position_in = '0;
                  end
                  CHAR_D: begin
                     hit             = 1'b1;
                     rsp_action_in   = ACT_DETACH;
                     rsp_position_in = '0;
                  end
                  default: begin
                     hit = 1'b0;
                  end
               endcase
            end
         end
      end

      if (hit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         board_address_ff <= '0;
         in_frame_ff      <= 1'b0;
         char_count_ff    <= '0;
         address_char_ff  <= '0;
         command_char_ff  <= '0;
         sub_char_ff      <= '0;
         servo_char_ff    <= '0;
         phase_ff         <= PH_SKIP;
         negative_ff      <= 1'b0;
         magnitude_ff     <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            board_address_ff <= csr_wr_data;
         end
         in_frame_ff     <= in_frame_in;
         char_count_ff   <= char_count_in;
         address_char_ff <= address_char_in;
         command_char_ff <= command_char_in;
         sub_char_ff     <= sub_char_in;
         servo_char_ff   <= servo_char_in;
         phase_ff        <= phase_in;
         negative_ff     <= negative_in;
         magnitude_ff    <= magnitude_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_action_ff   <= rsp_action_in;
      rsp_servo_ff    <= rsp_servo_in;
      rsp_position_ff <= rsp_position_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_action       = rsp_action_ff;
   assign rsp_servo_number = rsp_servo_ff;
   assign rsp_position     = rsp_position_ff;

   // A new command only follows an accepted end marker.
   a_rsp_after_end: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(req_fire && (req_rx_byte == CHAR_END)))
      else $error("command raised without an end marker");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      char_count_ff <= CNT_MAX)
      else $error("kept character count passed its limit");

   a_pos_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_action_ff != ACT_SET)) |-> (rsp_position_ff == 16'd0))
      else $error("attach or detach carries a position");

   a_skip_no_mag: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_SKIP) |-> (magnitude_ff == 16'd0 && !negative_ff))
      else $error("number value present before any sign or digit");

endmodule
